// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame header classifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define WHFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define WHFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/whfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame header classifier package
// Beat types, result codes and queue sizing shared by the classifier modules.
// ----------------------------------------------------------------------------
package whfc_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] CLASS_OTHER  = 2'd0;
  localparam logic [1:0] CLASS_BEACON = 2'd1;
  localparam logic [1:0] CLASS_DATA8  = 2'd2;
  localparam logic [1:0] CLASS_EAPOL  = 2'd3;

  localparam logic [2:0] SSID_NOT_BEACON = 3'd0;
  localparam logic [2:0] SSID_SHORT      = 3'd1;
  localparam logic [2:0] SSID_NO_ROOM    = 3'd2;
  localparam logic [2:0] SSID_INVALID    = 3'd3;
  localparam logic [2:0] SSID_VALID      = 3'd4;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [11:0] frame_length;
    logic        byte_last;
  } in_beat_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  ssid_char;
    logic [1:0]  frame_class;
    logic [7:0]  control_byte;
    logic [47:0] dest_addr;
    logic [47:0] src_addr;
    logic [47:0] bss_addr;
    logic [63:0] beacon_time;
    logic [15:0] beacon_period;
    logic [15:0] capability_bits;
    logic [2:0]  ssid_status;
    logic        run_last;
  } out_beat_t;

  typedef struct packed {
    logic      has_char;
    logic [7:0] char_byte;
    logic      has_sum;
    out_beat_t sum;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_head_t;

endpackage

// ===== rtl/whfc_front.sv =====
// ----------------------------------------------------------------------------
// Frame header classifier front end
// Takes one frame byte per beat, captures the header fields and queues the
// results that the byte causes as one job.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module whfc_front
  import whfc_pkg::*;
#(
  parameter int LENGTH_BITS = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  in_beat_t  beat,
  output job_push_t push
);

  localparam int CW = ((LENGTH_BITS > 8) ? LENGTH_BITS : 8) + 1;
  localparam logic [LENGTH_BITS-1:0] POS_DEST_LO = LENGTH_BITS'(4);
  localparam logic [LENGTH_BITS-1:0] POS_DEST_HI = LENGTH_BITS'(9);
  localparam logic [LENGTH_BITS-1:0] POS_SRC_LO  = LENGTH_BITS'(10);
  localparam logic [LENGTH_BITS-1:0] POS_SRC_HI  = LENGTH_BITS'(15);
  localparam logic [LENGTH_BITS-1:0] POS_BSS_LO  = LENGTH_BITS'(16);
  localparam logic [LENGTH_BITS-1:0] POS_BSS_HI  = LENGTH_BITS'(21);
  localparam logic [LENGTH_BITS-1:0] POS_TIME_LO = LENGTH_BITS'(24);
  localparam logic [LENGTH_BITS-1:0] POS_TIME_HI = LENGTH_BITS'(31);
  localparam logic [LENGTH_BITS-1:0] POS_ETH_HI  = LENGTH_BITS'(30);
  localparam logic [LENGTH_BITS-1:0] POS_ETH_LO  = LENGTH_BITS'(31);
  localparam logic [LENGTH_BITS-1:0] POS_PER_LO  = LENGTH_BITS'(32);
  localparam logic [LENGTH_BITS-1:0] POS_PER_HI  = LENGTH_BITS'(33);
  localparam logic [LENGTH_BITS-1:0] POS_CAP_LO  = LENGTH_BITS'(34);
  localparam logic [LENGTH_BITS-1:0] POS_CAP_HI  = LENGTH_BITS'(35);
  localparam logic [LENGTH_BITS-1:0] POS_SSID_LEN = LENGTH_BITS'(37);
  localparam logic [LENGTH_BITS-1:0] POS_SSID_FIRST = LENGTH_BITS'(38);
  localparam logic [LENGTH_BITS-1:0] LEN_SHORT   = LENGTH_BITS'(24);
  localparam logic [LENGTH_BITS-1:0] LEN_NO_ROOM = LENGTH_BITS'(36);
  localparam logic [LENGTH_BITS-1:0] LEN_EAPOL   = LENGTH_BITS'(34);
  localparam logic [LENGTH_BITS-1:0] IDX_MAX     = {LENGTH_BITS{1'b1}};
  localparam logic [CW-1:0] SSID_BASE = CW'(37);
  localparam logic [7:0] ETH_HI_BYTE = 8'h88;
  localparam logic [7:0] ETH_LO_BYTE = 8'h8E;
  localparam logic [1:0] TYPE_MGMT = 2'd0;
  localparam logic [1:0] TYPE_DATA = 2'd2;
  localparam logic [3:0] SUB_EIGHT = 4'h8;

  logic [LENGTH_BITS-1:0] idx_r, idx_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [7:0]  ctl_r, ctl_nxt;
  logic [47:0] dest_r, dest_nxt;
  logic [47:0] src_r, src_nxt;
  logic [47:0] bss_r, bss_nxt;
  logic [63:0] time_r, time_nxt;
  logic [15:0] per_r, per_nxt;
  logic [15:0] cap_r, cap_nxt;
  logic [7:0]  ssid_len_r, ssid_len_nxt;
  logic [1:0]  eth_r, eth_nxt;
  logic        start;
  logic [7:0]  b;
  logic [1:0]  cls;
  logic [2:0]  status;
  logic [CW-1:0] ssid_end;
  logic        bfields;

  always_comb begin
    start   = (idx_r == '0);
    len_nxt = start ? LENGTH_BITS'(beat.frame_length) : len_r;
    b       = (idx_r < len_nxt) ? beat.data_byte : 8'h00;

    ctl_nxt      = start ? 8'h00 : ctl_r;
    dest_nxt     = start ? '0 : dest_r;
    src_nxt      = start ? '0 : src_r;
    bss_nxt      = start ? '0 : bss_r;
    time_nxt     = start ? '0 : time_r;
    per_nxt      = start ? '0 : per_r;
    cap_nxt      = start ? '0 : cap_r;
    ssid_len_nxt = start ? '0 : ssid_len_r;
    eth_nxt      = start ? '0 : eth_r;

    if (start) begin
      ctl_nxt = b;
    end else if (idx_r >= POS_DEST_LO && idx_r <= POS_DEST_HI) begin
      dest_nxt = {dest_r[39:0], b};
    end else if (idx_r >= POS_SRC_LO && idx_r <= POS_SRC_HI) begin
      src_nxt = {src_r[39:0], b};
    end else if (idx_r >= POS_BSS_LO && idx_r <= POS_BSS_HI) begin
      bss_nxt = {bss_r[39:0], b};
    end else if (idx_r >= POS_TIME_LO && idx_r <= POS_TIME_HI) begin
      time_nxt[idx_r[2:0]*8 +: 8] = time_r[idx_r[2:0]*8 +: 8] | b;
    end else if (idx_r == POS_PER_LO) begin
      per_nxt[7:0] = b;
    end else if (idx_r == POS_PER_HI) begin
      per_nxt[15:8] = b;
    end else if (idx_r == POS_CAP_LO) begin
      cap_nxt[7:0] = b;
    end else if (idx_r == POS_CAP_HI) begin
      cap_nxt[15:8] = b;
    end else if (idx_r == POS_SSID_LEN) begin
      ssid_len_nxt = b;
    end

    if (idx_r == POS_ETH_HI && b == ETH_HI_BYTE) begin
      eth_nxt[0] = 1'b1;
    end
    if (idx_r == POS_ETH_LO && b == ETH_LO_BYTE) begin
      eth_nxt[1] = 1'b1;
    end

    if (ctl_nxt[3:2] == TYPE_MGMT && ctl_nxt[7:4] == SUB_EIGHT) begin
      cls = CLASS_BEACON;
    end else if (ctl_nxt[3:2] == TYPE_DATA && ctl_nxt[7:4] == SUB_EIGHT) begin
      cls = (len_nxt > LEN_EAPOL && eth_nxt == 2'b11) ? CLASS_EAPOL : CLASS_DATA8;
    end else begin
      cls = CLASS_OTHER;
    end

    ssid_end = CW'(ssid_len_nxt) + SSID_BASE;
    if (cls != CLASS_BEACON) begin
      status = SSID_NOT_BEACON;
    end else if (len_nxt < LEN_SHORT) begin
      status = SSID_SHORT;
    end else if (len_nxt <= LEN_NO_ROOM) begin
      status = SSID_NO_ROOM;
    end else if (ssid_len_nxt == 8'h00 || ssid_end >= CW'(len_nxt)) begin
      status = SSID_INVALID;
    end else begin
      status = SSID_VALID;
    end
    bfields = (cls == CLASS_BEACON) && (len_nxt >= LEN_SHORT);

    if (beat.byte_last) begin
      idx_nxt = '0;
    end else if (idx_r != IDX_MAX) begin
      idx_nxt = idx_r + LENGTH_BITS'(1);
    end else begin
      idx_nxt = idx_r;
    end

    push.job.has_char  = (status == SSID_VALID) && (idx_r >= POS_SSID_FIRST)
                         && (CW'(idx_r) <= ssid_end);
    push.job.char_byte = b;
    push.job.has_sum   = beat.byte_last;
    push.job.sum.result_kind     = KIND_SUMMARY;
    push.job.sum.ssid_char       = 8'h00;
    push.job.sum.frame_class     = cls;
    push.job.sum.control_byte    = ctl_nxt;
    push.job.sum.dest_addr       = dest_nxt;
    push.job.sum.src_addr        = src_nxt;
    push.job.sum.bss_addr        = bss_nxt;
    push.job.sum.beacon_time     = bfields ? time_nxt : '0;
    push.job.sum.beacon_period   = bfields ? per_nxt : '0;
    push.job.sum.capability_bits = bfields ? cap_nxt : '0;
    push.job.sum.ssid_status     = status;
    push.job.sum.run_last        = 1'b1;
    push.valid = take && (push.job.has_char || push.job.has_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      len_r      <= '0;
      ctl_r      <= '0;
      dest_r     <= '0;
      src_r      <= '0;
      bss_r      <= '0;
      time_r     <= '0;
      per_r      <= '0;
      cap_r      <= '0;
      ssid_len_r <= '0;
      eth_r      <= '0;
    end else if (take) begin
      idx_r      <= idx_nxt;
      len_r      <= len_nxt;
      ctl_r      <= ctl_nxt;
      dest_r     <= dest_nxt;
      src_r      <= src_nxt;
      bss_r      <= bss_nxt;
      time_r     <= time_nxt;
      per_r      <= per_nxt;
      cap_r      <= cap_nxt;
      ssid_len_r <= ssid_len_nxt;
      eth_r      <= eth_nxt;
    end
  end

  `WHFC_ASSERT(char_needs_beacon, push.valid && push.job.has_char |-> cls == CLASS_BEACON, "SSID character queued for a frame that is not a beacon")
  `WHFC_ASSERT(last_restarts_frame, take && beat.byte_last |=> idx_r == '0, "Byte index did not return to the frame start after the last byte")

endmodule

// ===== rtl/whfc_queue.sv =====
// ----------------------------------------------------------------------------
// Frame header classifier job queue
// Short first-in first-out store that decouples the front end from the
// result stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module whfc_queue
  import whfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  job_push_t push,
  input  logic      pop,
  output job_head_t head,
  output logic      full
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNTW-1:0] DEPTH_CNT = CNTW'(QUEUE_DEPTH);

  job_t            slots_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            do_pop;

  always_comb begin
    do_pop     = pop && (count_r != '0);
    wr_ptr_nxt = push.valid ? PW'((32'(wr_ptr_r) + 1) % QUEUE_DEPTH) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? PW'((32'(rd_ptr_r) + 1) % QUEUE_DEPTH) : rd_ptr_r;
    count_nxt  = count_r + CNTW'(push.valid) - CNTW'(do_pop);
    head.valid = (count_r != '0);
    head.job   = slots_r[rd_ptr_r];
    full       = (count_r == DEPTH_CNT);
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots_r[wr_ptr_r] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `WHFC_ASSERT(no_push_when_full, full |-> !push.valid, "Job written into a full queue")
  `WHFC_ASSERT(count_in_range, count_r <= DEPTH_CNT, "Queue fill count beyond its depth")

endmodule

// ===== rtl/whfc_back.sv =====
// ----------------------------------------------------------------------------
// Frame header classifier result stage
// Turns each queued job into one or two result beats through an output
// register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module whfc_back
  import whfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  job_head_t head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  logic      out_valid_r;
  out_beat_t out_beat_r, out_beat_nxt;
  logic      char_done_r, char_done_nxt;
  logic      load;
  logic      send_char;

  always_comb begin
    load      = !out_valid_r || !out_stall;
    send_char = head.job.has_char && !char_done_r;

    out_beat_nxt = head.job.sum;
    if (send_char) begin
      out_beat_nxt = '0;
      out_beat_nxt.result_kind = KIND_CHAR;
      out_beat_nxt.ssid_char   = head.job.char_byte;
      out_beat_nxt.run_last    = !head.job.has_sum;
    end

    pop           = load && head.valid && !(send_char && head.job.has_sum);
    char_done_nxt = char_done_r;
    if (load && head.valid) begin
      char_done_nxt = send_char && head.job.has_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      char_done_r <= 1'b0;
    end else begin
      char_done_r <= char_done_nxt;
      if (load) begin
        out_valid_r <= head.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head.valid) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  `WHFC_ASSERT(char_then_summary, out_valid && !out_stall && out_beat.result_kind == KIND_CHAR && !out_beat.run_last |=> out_valid && out_beat.result_kind == KIND_SUMMARY, "Summary did not follow its SSID character")
  `WHFC_ASSERT_ALWAYS(idle_after_reset, !rst_n |=> !out_valid, "Result valid straight after reset")

endmodule

// ===== rtl/wifi_frame_header_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// Wi-Fi frame header classifier
// Classifies 802.11 frames byte by byte, captures the header fields and
// returns SSID characters and an end-of-frame summary.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Beat type
// in_       input      in_valid / in_stall  in_beat_t, one frame byte
// out_      output     out_valid / out_stall out_beat_t, one result
//
// One byte is taken every cycle while the job queue has room; the front end
// classifies it in that cycle. The output register delivers one result per
// cycle while out_stall is low, so a last byte with an SSID character gives
// two results. Synchronous reset clears the frame state, queue and output.
// A stall on the output fills the queue, after which in_stall rises.
// ----------------------------------------------------------------------------
module wifi_frame_header_classifier_unit
  import whfc_pkg::*;
#(
  parameter int LENGTH_BITS = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  job_push_t push;
  job_head_t head;
  logic      pop;
  logic      q_full;
  logic      take;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  whfc_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .take (take),
    .beat (in_beat),
    .push (push)
  );

  whfc_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  whfc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

endmodule

// ===== sim/tb_wifi_frame_header_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// Frame header classifier testbench
// Streams 802.11 frames into the classifier one byte per beat, predicts every
// SSID character and end-of-frame summary from its own model of the header
// parser, and compares each returned beat field by field. Both channels idle
// and stall at random, apart from one calm stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_wifi_frame_header_classifier_unit;
  import whfc_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int IDLE_PCT      = 22;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_BYTES  = 1180;
  localparam int CALM_FROM     = 800;
  localparam int CALM_TO       = 1200;

  localparam logic [1:0] FTYPE_MGMT = 2'd0;
  localparam logic [1:0] FTYPE_CTRL = 2'd1;
  localparam logic [1:0] FTYPE_DATA = 2'd2;
  localparam logic [3:0] SUBTYPE_8  = 4'h8;
  localparam logic [7:0] ETH_HI     = 8'h88;
  localparam logic [7:0] ETH_LO     = 8'h8E;

  localparam int POS_DEST      = 4;
  localparam int POS_SRC       = 10;
  localparam int POS_BSS       = 16;
  localparam int POS_BSS_END   = 21;
  localparam int POS_TSF       = 24;
  localparam int POS_ETH_HI    = 30;
  localparam int POS_ETH_LO    = 31;
  localparam int POS_INTERVAL  = 32;
  localparam int POS_CAPS      = 34;
  localparam int POS_SSID_LEN  = 37;
  localparam int POS_SSID      = 38;
  localparam int MIN_BEACON    = 24;
  localparam int NO_ROOM_LEN   = 36;
  localparam int EAPOL_MIN_LEN = 34;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  wifi_frame_header_classifier_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always #1 clk = ~clk;

  // Parser state of the prediction.
  logic [11:0] frame_pos  = '0;
  logic [11:0] frame_len  = '0;
  logic [7:0]  hdr_fc     = '0;
  logic [47:0] dest_mac   = '0;
  logic [47:0] src_mac    = '0;
  logic [47:0] bss_mac    = '0;
  logic [63:0] tsf        = '0;
  logic [15:0] bcn_int    = '0;
  logic [15:0] caps       = '0;
  logic [7:0]  ssid_len   = '0;
  logic [1:0]  eth_hits   = '0;

  out_beat_t  frame_results[$];
  in_beat_t   byte_feed[$];
  logic [7:0] frame_buf[$];
  out_beat_t  expected_beat;

  int cycle_count    = 0;
  int mismatches     = 0;
  int frames_queued  = 0;
  int bytes_queued   = 0;
  int bytes_taken    = 0;
  int chars_seen     = 0;
  int summaries_seen = 0;
  logic calm;

  assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  function automatic logic [1:0] class_now();
    if (hdr_fc[3:2] == FTYPE_MGMT && hdr_fc[7:4] == SUBTYPE_8) return CLASS_BEACON;
    if (hdr_fc[3:2] == FTYPE_DATA && hdr_fc[7:4] == SUBTYPE_8)
      return (frame_len > EAPOL_MIN_LEN && eth_hits == 2'b11) ? CLASS_EAPOL : CLASS_DATA8;
    return CLASS_OTHER;
  endfunction

  function automatic logic [2:0] ssid_verdict(input logic [1:0] cls);
    if (cls != CLASS_BEACON) return SSID_NOT_BEACON;
    if (frame_len < MIN_BEACON) return SSID_SHORT;
    if (frame_len <= NO_ROOM_LEN) return SSID_NO_ROOM;
    if (ssid_len == 0 || POS_SSID_LEN + int'(ssid_len) >= int'(frame_len)) return SSID_INVALID;
    return SSID_VALID;
  endfunction

  task automatic classify_byte(input in_beat_t beat);
    int         pos;
    logic [7:0] b;
    logic [1:0] cls;
    logic [2:0] verdict;
    logic       beacon_fields;
    out_beat_t  r;
    pos = int'(frame_pos);
    if (pos == 0) begin
      hdr_fc    = '0;
      dest_mac  = '0;
      src_mac   = '0;
      bss_mac   = '0;
      tsf       = '0;
      bcn_int   = '0;
      caps      = '0;
      ssid_len  = '0;
      eth_hits  = '0;
      frame_len = beat.frame_length;
    end
    b = (pos < frame_len) ? beat.data_byte : 8'h00;

    if (pos == 0) hdr_fc = b;
    else if (pos >= POS_DEST && pos < POS_SRC) dest_mac = {dest_mac[39:0], b};
    else if (pos >= POS_SRC && pos < POS_BSS) src_mac = {src_mac[39:0], b};
    else if (pos >= POS_BSS && pos <= POS_BSS_END) bss_mac = {bss_mac[39:0], b};
    else if (pos >= POS_TSF && pos < POS_INTERVAL) tsf[8 * (pos - POS_TSF) +: 8] = b;
    else if (pos == POS_INTERVAL) bcn_int[7:0] = b;
    else if (pos == POS_INTERVAL + 1) bcn_int[15:8] = b;
    else if (pos == POS_CAPS) caps[7:0] = b;
    else if (pos == POS_CAPS + 1) caps[15:8] = b;
    else if (pos == POS_SSID_LEN) ssid_len = b;

    if (pos == POS_ETH_HI && b == ETH_HI) eth_hits[0] = 1'b1;
    if (pos == POS_ETH_LO && b == ETH_LO) eth_hits[1] = 1'b1;

    cls     = class_now();
    verdict = ssid_verdict(cls);

    if (verdict == SSID_VALID && pos >= POS_SSID && pos <= POS_SSID_LEN + int'(ssid_len)) begin
      r             = '0;
      r.result_kind = KIND_CHAR;
      r.ssid_char   = b;
      r.run_last    = !beat.byte_last;
      frame_results.push_back(r);
    end

    if (beat.byte_last) begin
      beacon_fields     = (cls == CLASS_BEACON) && (frame_len >= MIN_BEACON);
      r                 = '0;
      r.result_kind     = KIND_SUMMARY;
      r.frame_class     = cls;
      r.control_byte    = hdr_fc;
      r.dest_addr       = dest_mac;
      r.src_addr        = src_mac;
      r.bss_addr        = bss_mac;
      r.beacon_time     = beacon_fields ? tsf : '0;
      r.beacon_period   = beacon_fields ? bcn_int : '0;
      r.capability_bits = beacon_fields ? caps : '0;
      r.ssid_status     = verdict;
      r.run_last        = 1'b1;
      frame_results.push_back(r);
      frame_pos = '0;
    end else if (frame_pos != '1) begin
      frame_pos = frame_pos + 1'b1;
    end
  endtask

  function automatic logic [7:0] control_of(input logic [1:0] ftype, input logic [3:0] sub);
    return {sub, ftype, 2'($urandom_range(3))};
  endfunction

  // A negative fill value gives random content.
  task automatic fill_body(input logic [7:0] fc, input int n, input int fill);
    frame_buf.delete();
    frame_buf.push_back(fc);
    for (int i = 1; i < n; i++) frame_buf.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
  endtask

  task automatic queue_frame(input int sig_len, input int sent);
    in_beat_t beat;
    for (int i = 0; i < sent; i++) begin
      beat.data_byte    = (i < frame_buf.size()) ? frame_buf[i] : 8'($urandom);
      beat.frame_length = (i == 0) ? 12'(sig_len) : 12'($urandom);
      beat.byte_last    = (i == sent - 1);
      byte_feed.push_back(beat);
    end
    frames_queued++;
    bytes_queued += sent;
  endtask

  task automatic queue_beacon(input int len, input int ssid, input int sent, input int fill);
    fill_body(control_of(FTYPE_MGMT, SUBTYPE_8), len, fill);
    if (len > POS_SSID_LEN) frame_buf[POS_SSID_LEN] = 8'(ssid);
    queue_frame(len, sent);
  endtask

  task automatic queue_data8(input int len, input logic [1:0] hits, input int sent);
    fill_body(control_of(FTYPE_DATA, SUBTYPE_8), len, -1);
    if (len > POS_ETH_LO) begin
      frame_buf[POS_ETH_HI] = hits[0] ? ETH_HI : ~ETH_HI;
      frame_buf[POS_ETH_LO] = hits[1] ? ETH_LO : ~ETH_LO;
    end
    queue_frame(len, sent);
  endtask

  function automatic int sent_for(input int len);
    int r;
    int full;
    r    = $urandom_range(99);
    full = (len < 1) ? 1 : len;
    if (r < 70) return full;
    if (r < 85) return $urandom_range(1, full);
    return len + $urandom_range(1, 8);
  endfunction

  task automatic random_frame();
    int r;
    int len;
    r = $urandom_range(99);
    if (r < 35) begin
      len = $urandom_range(39, 90);
      queue_beacon(len, ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, len - 38),
                   sent_for(len), -1);
    end else if (r < 45) begin
      len = $urandom_range(0, 40);
      queue_beacon(len, $urandom_range(255), sent_for(len), -1);
    end else if (r < 65) begin
      len = $urandom_range(30, 70);
      queue_data8(len, ($urandom_range(3) != 0) ? 2'b11 : 2'($urandom_range(3)), sent_for(len));
    end else if (r < 85) begin
      len = $urandom_range(1, 60);
      fill_body(control_of(2'($urandom_range(3)), 4'($urandom_range(15))), len, -1);
      queue_frame(len, sent_for(len));
    end else begin
      fill_body(8'($urandom), $urandom_range(1, 60), -1);
      queue_frame($urandom_range(0, 4095), $urandom_range(1, 60));
    end
  endtask

  task automatic check_field(input string label, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: run timed out with %0d results outstanding", $time, frame_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        classify_byte(in_beat);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_feed.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_beat  <= byte_feed.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_results.size() == 0) begin
          $display("%0t ns: result beat expected none actual %h", $time, out_beat);
          mismatches++;
        end else begin
          expected_beat = frame_results.pop_front();
          check_field("result_kind", expected_beat.result_kind, out_beat.result_kind);
          check_field("ssid_char", expected_beat.ssid_char, out_beat.ssid_char);
          check_field("frame_class", expected_beat.frame_class, out_beat.frame_class);
          check_field("control_byte", expected_beat.control_byte, out_beat.control_byte);
          check_field("dest_addr", expected_beat.dest_addr, out_beat.dest_addr);
          check_field("src_addr", expected_beat.src_addr, out_beat.src_addr);
          check_field("bss_addr", expected_beat.bss_addr, out_beat.bss_addr);
          check_field("beacon_time", expected_beat.beacon_time, out_beat.beacon_time);
          check_field("beacon_period", expected_beat.beacon_period, out_beat.beacon_period);
          check_field("capability_bits", expected_beat.capability_bits,
                      out_beat.capability_bits);
          check_field("ssid_status", expected_beat.ssid_status, out_beat.ssid_status);
          check_field("run_last", expected_beat.run_last, out_beat.run_last);
          if (expected_beat.result_kind == KIND_CHAR) chars_seen++;
          else summaries_seen++;
        end
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin
    int random_start;
    queue_beacon(48, 6, 48, 255);
    queue_beacon(20, 0, 20, -1);
    queue_beacon(36, 5, 36, -1);
    queue_beacon(45, 0, 45, -1);
    queue_beacon(45, 8, 45, -1);
    queue_beacon(46, 8, 46, 0);
    queue_beacon(50, 4, 60, -1);
    queue_beacon(60, 10, 12, -1);
    queue_data8(35, 2'b11, 35);
    queue_data8(34, 2'b11, 34);
    queue_data8(40, 2'b01, 40);
    fill_body({4'h4, FTYPE_CTRL, 2'b11}, 24, 0);
    queue_frame(24, 24);
    fill_body(control_of(FTYPE_MGMT, SUBTYPE_8), 8, 255);
    queue_frame(0, 8);
    fill_body(8'hFF, 1, -1);
    queue_frame(4095, 1);

    random_start = bytes_queued;
    while (bytes_queued - random_start < RANDOM_BYTES) random_frame();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (bytes_taken != bytes_queued) @(posedge clk);
    while (frame_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d frames in %0d byte beats; checked %0d SSID characters and %0d summaries.",
             frames_queued, bytes_taken, chars_seen, summaries_seen);
    $display("Frames covered every class and SSID status, early ends and bytes past the length.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
